FILE: src/chti_pkg.sv
// chained hash table package: sizes, pointer types, controller/datapath interface
// no dependencies
`timescale 1ns / 1ps

package chti_pkg;
    localparam int MaxBuckets = 64;
    localparam int MaxNodes   = 256;
    localparam int DataWidth  = 64;
    localparam int KeyWidth   = 64;
    localparam int PtrWidth   = 9;
    localparam int BktWidth   = 6;
    localparam int CntWidth   = 9;

    localparam logic [PtrWidth-1:0] NullIdx = PtrWidth'(MaxNodes);

    localparam logic CmdInsert = 1'b0;
    localparam logic CmdRemove = 1'b1;

    localparam logic RegBucketCount = 1'b0;
    localparam logic RegNodeLimit   = 1'b1;

    typedef logic [PtrWidth-1:0] t_ptr;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item, start modulo
        logic mod_step;   // one restoring step of the modulo
        logic head_rd;    // register bucket head
        logic alloc;      // insert: write node, link head
        logic node_rd;    // remove: read node at cursor
        logic advance;    // remove: move cursor along chain
        logic unlink;     // remove: unlink matched node
        logic free_push;  // remove: push unlinked node on free list
        logic respond;    // load result register
        logic resp_ok;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic mod_done;
        logic can_alloc;
        logic cur_null;
        logic key_match;
        logic walk_limit;
    } t_status;
endpackage

FILE: src/chti_datapath.sv
// chained hash table datapath: modulo unit, bucket heads, node memories, free list
// depends on chti_pkg
`timescale 1ns / 1ps

module chti_datapath import chti_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    input  logic                i_command,
    input  logic [KeyWidth-1:0] i_key_hash,
    input  logic                i_has_payload,
    input  logic [63:0]         i_payload,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_ok,
    output logic [CntWidth-1:0] o_active_count
);
    logic [6:0]  r_bucket_count;
    logic [8:0]  r_node_limit;
    logic [6:0]  w_eff_buckets;
    logic [8:0]  w_eff_limit;

    logic                r_cmd_rm;
    logic [KeyWidth-1:0] r_key;
    logic                r_has_pl;
    logic [DataWidth-1:0] r_pl;

    // restoring modulo, one quotient bit per step
    logic [KeyWidth-1:0] r_mod_q;
    logic [6:0]          r_mod_rem;
    logic [6:0]          r_mod_cnt;
    logic [7:0]          w_trial;
    logic [6:0]          w_rem_next;

    t_ptr r_bucket_head [MaxBuckets];
    logic [MaxBuckets-1:0] r_head_valid;
    t_ptr r_head;
    t_ptr r_prev;
    t_ptr r_cur;
    t_ptr r_next_rd;
    t_ptr r_free_next;
    logic [KeyWidth-1:0] r_key_rd;
    logic [CntWidth-1:0] r_steps;
    t_ptr r_free_head;
    logic [CntWidth-1:0] r_nodes_used;
    logic [CntWidth-1:0] r_active;
    logic                r_res_ok;
    logic [CntWidth-1:0] r_res_count;

    t_ptr                 r_node_next [MaxNodes];
    logic [KeyWidth-1:0]  r_node_key  [MaxNodes];
    logic [DataWidth-1:0] r_node_data [MaxNodes];

    logic [BktWidth-1:0] w_bkt;
    t_ptr w_new_node;
    logic w_from_free;

    assign w_eff_buckets = (r_bucket_count == 7'd0) ? 7'd1 :
                           (r_bucket_count > 7'(MaxBuckets)) ? 7'(MaxBuckets) : r_bucket_count;
    assign w_eff_limit   = (r_node_limit > 9'(MaxNodes)) ? 9'(MaxNodes) : r_node_limit;
    assign w_bkt         = r_mod_rem[BktWidth-1:0];

    assign w_trial    = {r_mod_rem, r_mod_q[KeyWidth-1]};
    assign w_rem_next = (w_trial >= {1'b0, w_eff_buckets}) ?
                        7'(w_trial - {1'b0, w_eff_buckets}) : w_trial[6:0];

    assign w_from_free = (r_free_head != NullIdx);
    assign w_new_node  = w_from_free ? r_free_head : r_nodes_used;

    assign o_status.is_remove  = r_cmd_rm;
    assign o_status.mod_done   = (r_mod_cnt == 7'd0);
    assign o_status.can_alloc  = w_from_free || (r_nodes_used < w_eff_limit);
    assign o_status.cur_null   = (r_cur == NullIdx);
    assign o_status.key_match  = (r_key_rd == r_key);
    assign o_status.walk_limit = (r_steps == CntWidth'(MaxNodes));
    assign o_ok                = r_res_ok;
    assign o_active_count      = r_res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= 7'd16;
            r_node_limit   <= 9'd256;
            r_head_valid   <= '0;
            r_free_head    <= NullIdx;
            r_nodes_used   <= '0;
            r_active       <= '0;
            r_mod_cnt      <= '0;
            r_res_ok       <= 1'b0;
            r_res_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegBucketCount) r_bucket_count <= i_cfg_data[6:0];
                else r_node_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_mod_cnt <= 7'(KeyWidth);
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt - 7'd1;
            end
            if (i_cmd.alloc) begin
                r_head_valid[w_bkt] <= 1'b1;
                if (w_from_free) r_free_head <= r_free_next;
                else r_nodes_used <= r_nodes_used + 9'd1;
                r_active <= r_active + 9'd1;
            end
            if (i_cmd.unlink) begin
                if (r_prev == NullIdx) r_head_valid[w_bkt] <= 1'b1;
            end
            if (i_cmd.free_push) begin
                r_free_head <= r_cur;
                if (r_active != '0) r_active <= r_active - 9'd1;
            end
            if (i_cmd.respond) begin
                r_res_ok    <= i_cmd.resp_ok;
                r_res_count <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_rm  <= i_command;
            r_key     <= i_key_hash;
            r_has_pl  <= i_has_payload;
            r_pl      <= i_payload[DataWidth-1:0];
            r_mod_q   <= i_key_hash;
            r_mod_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_q   <= {r_mod_q[KeyWidth-2:0], 1'b0};
            r_mod_rem <= w_rem_next;
        end
        if (i_cmd.head_rd) begin
            r_head      <= r_head_valid[w_bkt] ? r_bucket_head[w_bkt] : NullIdx;
            r_cur       <= r_head_valid[w_bkt] ? r_bucket_head[w_bkt] : NullIdx;
            r_prev      <= NullIdx;
            r_steps     <= '0;
            r_free_next <= r_node_next[r_free_head[7:0]];
        end
        if (i_cmd.node_rd) begin
            r_next_rd <= r_node_next[r_cur[7:0]];
            r_key_rd  <= r_node_key[r_cur[7:0]];
        end
        if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_next_rd;
            r_steps <= r_steps + 9'd1;
        end
        if (i_cmd.alloc) begin
            r_bucket_head[w_bkt]           <= w_new_node;
            r_node_key[w_new_node[7:0]]    <= r_key;
            r_node_next[w_new_node[7:0]]   <= r_head;
            if (r_has_pl) r_node_data[w_new_node[7:0]] <= r_pl;
        end
        if (i_cmd.unlink) begin
            if (r_prev == NullIdx) r_bucket_head[w_bkt] <= r_next_rd;
            else r_node_next[r_prev[7:0]] <= r_next_rd;
            r_node_key[r_cur[7:0]]  <= '0;
        end
        if (i_cmd.free_push) begin
            r_node_next[r_cur[7:0]] <= r_free_head;
        end
    end
endmodule

FILE: src/chti_ctrl.sv
// chained hash table controller: sequences modulo, insert and chain walk
// depends on chti_pkg
`timescale 1ns / 1ps

module chti_ctrl import chti_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_HEAD, S_DISPATCH, S_READ, S_CHECK, S_FREE, S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_ok;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:     o_cmd.load = i_in_valid;
            S_MOD:      o_cmd.mod_step = !i_status.mod_done;
            S_HEAD:     o_cmd.head_rd = 1'b1;
            S_DISPATCH: o_cmd.alloc = !i_status.is_remove && i_status.can_alloc;
            S_READ:     o_cmd.node_rd = !i_status.cur_null && !i_status.walk_limit;
            S_CHECK: begin
                o_cmd.unlink  = i_status.key_match;
                o_cmd.advance = !i_status.key_match;
            end
            S_FREE:     o_cmd.free_push = 1'b1;
            S_DONE: begin
                o_cmd.respond = w_out_free;
                o_cmd.resp_ok = r_ok;
            end
            default:    o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:     if (i_in_valid) r_state <= S_MOD;
                S_MOD:      if (i_status.mod_done) r_state <= S_HEAD;
                S_HEAD:     r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    if (i_status.is_remove) begin
                        r_state <= S_READ;
                    end else begin
                        r_ok    <= i_status.can_alloc;
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    if (i_status.cur_null || i_status.walk_limit) begin
                        r_ok    <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_status.key_match) begin
                        r_ok    <= 1'b1;
                        r_state <= S_FREE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_FREE:     r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/chained_hash_table_insert_remove.sv
// chained hash table with node pool and free list, top level
// depends on chti_pkg, chti_ctrl, chti_datapath
//
// channel  | handshake              | payload
// in       | i_in_valid/o_in_ready  | i_command i_key_hash i_has_payload i_payload
// out      | o_out_valid/i_out_ready| o_ok o_active_count
// cfg      | i_cfg_we               | i_cfg_index i_cfg_data
//
// one item at a time: insert runs the 64-step bit-serial modulo, a bucket head read
// and node write; remove runs the modulo, head read and a node-by-node chain walk
// result waits in an output register; next item accepted once it is loaded
// synchronous active-low reset, no clearing pass (bucket heads have valid bits)
`timescale 1ns / 1ps

module chained_hash_table_insert_remove import chti_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [KeyWidth-1:0] i_key_hash,
    input  logic                i_has_payload,
    input  logic [63:0]         i_payload,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ok,
    output logic [CntWidth-1:0] o_active_count,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [8:0]          i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    chti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    chti_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_key_hash     (i_key_hash),
        .i_has_payload  (i_has_payload),
        .i_payload      (i_payload),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_ok           (o_ok),
        .o_active_count (o_active_count)
    );

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_active_count <= CntWidth'(MaxNodes))
        else $error("active count above pool size");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.alloc, w_cmd.unlink, w_cmd.advance}))
        else $error("conflicting datapath commands");

    a_failed_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && !o_ok |-> $stable(o_active_count))
        else $error("failed item changed active count");
endmodule

FILE: test/chti_checker.sv
// chained hash table checker: watches the item and result channels, predicts each result
// with its own table model and compares; depends on chti_pkg
`timescale 1ns / 1ps

module chti_checker import chti_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_command,
    input  logic [KeyWidth-1:0] i_key_hash,
    input  logic                i_has_payload,
    input  logic [63:0]         i_payload,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_ok,
    input  logic [CntWidth-1:0] i_active_count,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    typedef struct packed {
        logic                ok;
        logic [CntWidth-1:0] count;
    } t_result;

    logic [6:0]          bucket_cfg;
    logic [8:0]          limit_cfg;
    t_ptr                heads [MaxBuckets];
    t_ptr                links [MaxNodes];
    logic [KeyWidth-1:0] keys  [MaxNodes];
    logic [63:0]         datas [MaxNodes];
    t_ptr                free_top;
    logic [8:0]          fresh_used;
    logic [8:0]          held;
    t_result             awaited [$];

    function automatic int unsigned bucket_of(logic [KeyWidth-1:0] key);
        int unsigned nb;
        nb = bucket_cfg;
        if (nb == 0) nb = 1;
        if (nb > MaxBuckets) nb = MaxBuckets;
        return int'(key % 64'(nb));
    endfunction

    function automatic logic table_insert(logic [KeyWidth-1:0] key, logic with_data,
                                          logic [63:0] data);
        int unsigned b;
        int unsigned lim;
        t_ptr n;
        b = bucket_of(key);
        lim = (limit_cfg > MaxNodes) ? MaxNodes : limit_cfg;
        if (free_top != NullIdx) begin
            n = free_top;
            free_top = links[n];
        end else if (fresh_used < lim) begin
            n = fresh_used;
            fresh_used++;
        end else begin
            return 1'b0;
        end
        keys[n] = key;
        if (with_data) datas[n] = data;
        links[n] = heads[b];
        heads[b] = n;
        held++;
        return 1'b1;
    endfunction

    function automatic logic table_remove(logic [KeyWidth-1:0] key);
        int unsigned b;
        int unsigned steps;
        t_ptr prev;
        t_ptr cur;
        b = bucket_of(key);
        prev = NullIdx;
        cur = heads[b];
        steps = 0;
        while (cur != NullIdx && steps < MaxNodes) begin
            if (keys[cur] == key) begin
                if (prev != NullIdx) links[prev] = links[cur];
                else heads[b] = links[cur];
                keys[cur] = '0;
                links[cur] = free_top;
                free_top = cur;
                if (held > 0) held--;
                return 1'b1;
            end
            prev = cur;
            cur = links[cur];
            steps++;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            bucket_cfg = 7'd16;
            limit_cfg = 9'd256;
            foreach (heads[i]) heads[i] = NullIdx;
            foreach (links[i]) links[i] = NullIdx;
            free_top = NullIdx;
            fresh_used = '0;
            held = '0;
            awaited.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegBucketCount) bucket_cfg = i_cfg_data[6:0];
                else limit_cfg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = '{ok: i_ok, count: i_active_count};
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result ok=%0b count=%0d", $time, i_ok,
                             i_active_count);
                    o_fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (got.ok !== want.ok)
                        $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
                    if (got.count !== want.count)
                        $display("%0t: active_count expected %0d actual %0d", $time,
                                 want.count, got.count);
                    if (got !== want) o_fail_count++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CmdInsert)
                    want.ok = table_insert(i_key_hash, i_has_payload, i_payload);
                else
                    want.ok = table_remove(i_key_hash);
                want.count = held;
                awaited.push_back(want);
            end
        end
        o_pending = awaited.size();
    end
endmodule

FILE: test/tb_chained_hash_table_insert_remove.sv
// testbench top for the chained hash table: drives items, configuration and stalls,
// gives the verdict; depends on chti_pkg, the block and chti_checker
`timescale 1ns / 1ps

module tb_chained_hash_table_insert_remove;
    import chti_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_command;
    logic [KeyWidth-1:0] i_key_hash;
    logic                i_has_payload;
    logic [63:0]         i_payload;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_ok;
    logic [CntWidth-1:0] o_active_count;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [8:0]          i_cfg_data;
    int                  fail_count;
    int                  pending;
    logic                hold_off;
    logic                stream_on;
    logic [KeyWidth-1:0] key_pool [$];

    chained_hash_table_insert_remove u_dut (.*);

    chti_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_command, .i_key_hash,
        .i_has_payload, .i_payload, .i_out_valid(o_out_valid), .i_out_ready, .i_ok(o_ok),
        .i_active_count(o_active_count), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb_chained_hash_table_insert_remove NOT OK");
        $finish;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int unsigned n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (stream_on || $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                n = gap_len();
                i_out_ready <= (n == 0);
                repeat (n) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic cmd, logic [63:0] key, logic with_data, logic [63:0] data);
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_key_hash    <= key;
        i_has_payload <= with_data;
        i_payload     <= data;
        // ready only changes at a rising edge, so its value here holds at the next one
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == CmdInsert) key_pool.push_back(key);
    endtask

    task automatic offer(logic cmd, logic [63:0] key, logic with_data, logic [63:0] data,
                         logic gaps);
        int unsigned n;
        n = gaps ? gap_len() : 0;
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        send_item(cmd, key, with_data, data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if ($urandom_range(0, 1)) return 64'($urandom_range(0, 300));
        return rand64();
    endfunction

    task automatic random_phase(int count, int unsigned remove_pct);
        logic cmd;
        for (int k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 99) < remove_pct) ? CmdRemove : CmdInsert;
            offer(cmd, pick_key(), 1'($urandom_range(0, 1)), rand64(), 1'b1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = CmdInsert;
        i_key_hash = '0;
        i_has_payload = 1'b0;
        i_payload = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegBucketCount;
        i_cfg_data = '0;
        hold_off = 1'b0;
        stream_on = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, remove on empty, duplicates, chain middle, pool full
        offer(CmdRemove, 64'd5, 1'b0, '0, 1'b0);
        offer(CmdInsert, '1, 1'b1, '1, 1'b0);
        offer(CmdInsert, '0, 1'b0, '0, 1'b0);
        offer(CmdInsert, 64'd16, 1'b1, 64'h5555_5555_5555_5555, 1'b0);
        offer(CmdInsert, 64'd32, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer(CmdInsert, 64'd16, 1'b0, '0, 1'b0);
        offer(CmdRemove, 64'd16, 1'b0, '0, 1'b0);
        offer(CmdRemove, 64'd16, 1'b0, '0, 1'b0);
        offer(CmdRemove, 64'd16, 1'b0, '0, 1'b0);
        offer(CmdRemove, '1, 1'b0, '1, 1'b0);
        offer(CmdRemove, 64'd48, 1'b0, '0, 1'b0);
        drain();
        write_reg(RegNodeLimit, 9'd2);
        write_reg(RegBucketCount, 9'd0);
        offer(CmdInsert, 64'd7, 1'b1, 64'd1, 1'b0);
        offer(CmdInsert, 64'd8, 1'b1, 64'd2, 1'b0);
        offer(CmdInsert, 64'd9, 1'b1, 64'd3, 1'b0);
        offer(CmdRemove, 64'd7, 1'b0, '0, 1'b0);
        offer(CmdInsert, 64'd9, 1'b1, 64'd3, 1'b0);
        offer(CmdRemove, 64'd9, 1'b0, '0, 1'b0);
        offer(CmdRemove, 64'd9, 1'b0, '0, 1'b0);
        drain();
        write_reg(RegBucketCount, 9'd127);
        write_reg(RegNodeLimit, 9'd511);

        random_phase(300, 30);
        // sender pauses until every result is back, then receiver holds off
        drain();
        write_reg(RegBucketCount, 9'd1);
        hold_off = 1'b1;
        random_phase(150, 40);
        drain();
        write_reg(RegBucketCount, 9'd64);
        write_reg(RegNodeLimit, 9'd256);
        random_phase(400, 45);
        drain();
        write_reg(RegBucketCount, 9'($urandom_range(1, 64)));
        write_reg(RegNodeLimit, 9'($urandom_range(2, 40)));
        random_phase(350, 35);
        drain();
        write_reg(RegNodeLimit, 9'd3);
        random_phase(200, 50);
        drain();
        write_reg(RegBucketCount, 9'd3);
        write_reg(RegNodeLimit, 9'd256);
        stream_on = 1'b1;
        random_phase(250, 20);
        stream_on = 1'b0;
        random_phase(280, 60);
        drain();
        if (fail_count == 0) begin
            $display("tb_chained_hash_table_insert_remove OK");
        end else begin
            $display("tb_chained_hash_table_insert_remove NOT OK");
        end
        $finish;
    end
endmodule
